>>> rtl/core/ostm_pkg.sv
// Package for the overlay slot timer manager: constants, item types,
// controller states and the controller/datapath command structs. No dependencies.
package ostm_pkg;

   localparam int SLOTS = 16;
   localparam int ROWS = 12;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int MAX_OUT = 15;
   localparam logic [7:0] FOREVER = 8'd255;

   localparam logic [1:0] KIND_SET = 2'd0;
   localparam logic [1:0] KIND_DEL = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;
   localparam logic [1:0] KIND_SWEEP = 2'd3;

   localparam logic [1:0] ACT_STATUS = 2'd0;
   localparam logic [1:0] ACT_DRAW = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NEW = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] id;
      logic [7:0] x_pos;
      logic [3:0] y_pos;
      logic [7:0] text_length;
      logic [7:0] duration;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] out_id;
      logic [7:0] out_x;
      logic [3:0] out_row;
      logic [7:0] out_length;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_CLEAR, S_ROWSCAN, S_PLACE, S_DRAW, S_STATUS,
      S_DELCLR, S_TICK, S_SWEEP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // capture request, clear scan index
      logic scan_next;    // advance scan index
      logic scan_reset;   // restart scan index (before row scan)
      logic mark_row;     // accumulate busy row of current slot
      logic pick_fresh;   // latch scan index as target slot
      logic commit_place; // write slot with request and chosen row
      logic invalidate;   // clear valid of target or scanned slot
      logic use_scan;     // invalidate/emit concerns scanned slot
      logic tick_step;    // decrement scanned slot
      logic emit;
      logic [1:0] action;
      logic [1:0] status;
      logic       last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] kind;
      logic id_valid;     // request id names a valid slot
      logic scan_done;    // scan index at last slot
      logic scan_free;    // scanned slot free (and not slot 0)
      logic scan_expired; // scanned slot valid with zero remaining
      logic sweep_full;   // MAX_OUT clears already emitted
      logic sweep_last;   // a clear of the scanned slot ends the sweep
      logic have_target;
   } stat_type;

endpackage

>>> rtl/core/overlay_slot_timer_manager.sv
// Top level of the overlay slot timer manager: controller plus datapath.
// Depends on ostm_pkg, ostm_controller, ostm_datapath.
// Busy after accept until the item is done; a set with a new id runs a free-id scan and then a row scan,
// and ends after the free-id scan when no id is free. One item at a time.
// Results leave on rsp_strobe in the cycle after they are formed; receiver cannot stall.
// Synchronous reset clears all slots to free and returns the controller to idle.
module overlay_slot_timer_manager (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ostm_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ostm_pkg::rsp_type rsp_item
);

   ostm_pkg::cmd_type  cmd;
   ostm_pkg::stat_type stat;

   ostm_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   ostm_datapath u_dp (
      .clock(clock), .reset(reset), .req_item(req_item), .cmd(cmd),
      .stat(stat), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

endmodule

>>> rtl/core/ostm_datapath.sv
// Datapath of the overlay slot timer manager: slot table, scan index,
// busy-row accumulation and result register. Depends on ostm_pkg.
module ostm_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ostm_pkg::req_type req_item,
   input  ostm_pkg::cmd_type cmd,
   output ostm_pkg::stat_type stat,
   output logic             rsp_strobe,
   output ostm_pkg::rsp_type rsp_item
);

   localparam int SW = ostm_pkg::SLOT_W;

   logic [ostm_pkg::SLOTS-1:0] valid_ff, valid_in;
   logic [7:0] x_ff [ostm_pkg::SLOTS];
   logic [3:0] row_ff [ostm_pkg::SLOTS];
   logic [7:0] len_ff [ostm_pkg::SLOTS];
   logic [7:0] rem_ff [ostm_pkg::SLOTS];

   ostm_pkg::req_type req_ff;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] tgt_ff;
   logic          tgt_set_ff, tgt_set_in;
   logic [15:0]   busy_ff, busy_in;
   logic [15:0]   free_rows;
   logic [3:0]    chosen;
   logic [3:0]    cnt_ff, cnt_in;
   logic          strobe_ff;
   ostm_pkg::rsp_type rsp_ff, rsp_in;
   logic [SW-1:0] sel;
   logic          id_ok;
   logic [3:0]    first_free;
   logic          any_free;
   logic          later_expired;

   assign id_ok = (req_ff.id != 8'd0) && (req_ff.id < 8'(ostm_pkg::SLOTS));
   assign sel = cmd.use_scan ? scan_ff : tgt_ff;

   // an updated slot gives up its own row before the new row is chosen
   always_comb begin
      free_rows = ~busy_ff;
      if (valid_ff[tgt_ff] && row_ff[tgt_ff] < 4'(ostm_pkg::ROWS))
         free_rows[row_ff[tgt_ff]] = 1'b1;
      first_free = 4'd0;
      any_free = 1'b0;
      for (int i = ostm_pkg::ROWS - 1; i >= 0; i--) begin
         if (free_rows[i]) begin
            first_free = 4'(i);
            any_free = 1'b1;
         end
      end
      if (req_ff.y_pos < 4'(ostm_pkg::ROWS) && free_rows[req_ff.y_pos])
         chosen = req_ff.y_pos;
      else if (any_free)
         chosen = first_free;
      else
         chosen = req_ff.y_pos;
   end

   always_comb begin
      later_expired = 1'b0;
      for (int i = 0; i < ostm_pkg::SLOTS; i++) begin
         if (i > int'(scan_ff) && valid_ff[i] && rem_ff[i] == 8'd0)
            later_expired = 1'b1;
      end
   end

   always_comb begin
      stat.kind = req_ff.kind;
      stat.id_valid = id_ok && valid_ff[req_ff.id[SW-1:0]];
      stat.scan_done = (scan_ff == SW'(ostm_pkg::SLOTS - 1));
      stat.scan_free = !valid_ff[scan_ff] && (scan_ff != '0);
      stat.scan_expired = valid_ff[scan_ff] && (rem_ff[scan_ff] == 8'd0);
      stat.sweep_full = (cnt_ff == 4'(ostm_pkg::MAX_OUT));
      stat.sweep_last = !later_expired || (cnt_ff == 4'(ostm_pkg::MAX_OUT - 1));
      stat.have_target = tgt_set_ff;
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.load || cmd.scan_reset) scan_in = '0;
      else if (cmd.scan_next) scan_in = scan_ff + 1'b1;
      busy_in = busy_ff;
      if (cmd.load) busy_in = '0;
      else if (cmd.mark_row && valid_ff[scan_ff] && row_ff[scan_ff] < 4'(ostm_pkg::ROWS))
         busy_in[row_ff[scan_ff]] = 1'b1;
      tgt_set_in = tgt_set_ff;
      if (cmd.load) tgt_set_in = 1'b0;
      else if (cmd.pick_fresh) tgt_set_in = 1'b1;
      valid_in = valid_ff;
      if (cmd.commit_place) valid_in[tgt_ff] = 1'b1;
      if (cmd.invalidate) valid_in[sel] = 1'b0;
      cnt_in = cnt_ff;
      if (cmd.load) cnt_in = '0;
      else if (cmd.emit) cnt_in = cnt_ff + 1'b1;
      rsp_in = '0;
      rsp_in.action = cmd.action;
      rsp_in.status = cmd.status;
      rsp_in.last = cmd.last;
      case (cmd.action)
         ostm_pkg::ACT_STATUS: begin
            rsp_in.out_id = (cmd.status == ostm_pkg::ST_FAIL && req_ff.kind ==
               ostm_pkg::KIND_SET) ? 8'd0 :
               (cmd.status == ostm_pkg::ST_FAIL) ? req_ff.id : 8'(tgt_ff);
         end
         default: begin
            rsp_in.out_id = 8'(sel);
            rsp_in.out_x = x_ff[sel];
            rsp_in.out_row = row_ff[sel];
            rsp_in.out_length = len_ff[sel];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         strobe_ff <= 1'b0;
         tgt_set_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         strobe_ff <= cmd.emit;
         tgt_set_ff <= tgt_set_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      busy_ff <= busy_in;
      rsp_ff <= rsp_in;
      if (cmd.load) begin
         req_ff <= req_item;
         tgt_ff <= req_item.id[SW-1:0];
      end else if (cmd.pick_fresh) begin
         tgt_ff <= scan_ff;
      end
      if (cmd.commit_place) begin
         x_ff[tgt_ff] <= req_ff.x_pos;
         row_ff[tgt_ff] <= chosen;
         len_ff[tgt_ff] <= req_ff.text_length;
         rem_ff[tgt_ff] <= req_ff.duration;
      end
      if (cmd.tick_step && valid_ff[scan_ff] && rem_ff[scan_ff] != 8'd0
          && rem_ff[scan_ff] != ostm_pkg::FOREVER)
         rem_ff[scan_ff] <= rem_ff[scan_ff] - 8'd1;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item = rsp_ff;

`ifndef NO_ASSERTIONS
   a_place_target: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_place |=> valid_ff[$past(tgt_ff)])
      else $error("placed slot not valid");
   a_no_zero_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_place |-> tgt_ff != '0)
      else $error("slot zero placed");
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(ostm_pkg::MAX_OUT))
      else $error("sweep overflow");
`endif

endmodule

>>> rtl/core/ostm_controller.sv
// Controller state machine of the overlay slot timer manager: sequences
// scans and result emission. Depends on ostm_pkg.
module ostm_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ostm_pkg::stat_type stat,
   output ostm_pkg::cmd_type  cmd
);

   ostm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ostm_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ostm_pkg::S_IDLE: if (start) state_in = ostm_pkg::S_FIND;
         ostm_pkg::S_FIND: begin
            case (stat.kind)
               ostm_pkg::KIND_SET: begin
                  if (stat.id_valid) state_in = ostm_pkg::S_CLEAR;
                  else if (stat.have_target) state_in = ostm_pkg::S_ROWSCAN;
                  else if (stat.scan_free) state_in = ostm_pkg::S_ROWSCAN;
                  else if (stat.scan_done) state_in = ostm_pkg::S_STATUS;
               end
               ostm_pkg::KIND_DEL:
                  state_in = stat.id_valid ? ostm_pkg::S_DELCLR : ostm_pkg::S_STATUS;
               ostm_pkg::KIND_TICK: state_in = ostm_pkg::S_TICK;
               default: state_in = ostm_pkg::S_SWEEP;
            endcase
         end
         ostm_pkg::S_CLEAR: state_in = ostm_pkg::S_ROWSCAN;
         ostm_pkg::S_ROWSCAN: if (stat.scan_done) state_in = ostm_pkg::S_PLACE;
         ostm_pkg::S_PLACE: state_in = ostm_pkg::S_DRAW;
         ostm_pkg::S_DRAW: state_in = ostm_pkg::S_STATUS;
         ostm_pkg::S_STATUS: state_in = ostm_pkg::S_IDLE;
         ostm_pkg::S_DELCLR: state_in = ostm_pkg::S_STATUS;
         ostm_pkg::S_TICK: if (stat.scan_done) state_in = ostm_pkg::S_IDLE;
         ostm_pkg::S_SWEEP: if (stat.scan_done) state_in = ostm_pkg::S_IDLE;
         default: state_in = ostm_pkg::S_IDLE;
      endcase
   end

   // the status after a set whose id was valid reports ST_OK rather than ST_NEW
   logic updated_ff, updated_in;
   logic failed_ff, failed_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         updated_ff <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         updated_ff <= updated_in;
         failed_ff <= failed_in;
      end
   end

   always_comb begin
      cmd = '0;
      updated_in = updated_ff;
      failed_in = failed_ff;
      busy = (state_ff != ostm_pkg::S_IDLE);
      case (state_ff)
         ostm_pkg::S_IDLE: begin
            cmd.load = start;
            updated_in = 1'b0;
            failed_in = 1'b0;
         end
         ostm_pkg::S_FIND: begin
            case (stat.kind)
               ostm_pkg::KIND_SET: begin
                  if (stat.id_valid) begin
                     updated_in = 1'b1;
                  end else if (stat.scan_free) begin
                     cmd.pick_fresh = 1'b1;
                     cmd.scan_reset = 1'b1;
                  end else if (stat.scan_done) begin
                     failed_in = 1'b1;
                  end else begin
                     cmd.scan_next = 1'b1;
                  end
               end
               ostm_pkg::KIND_DEL: failed_in = !stat.id_valid;
               default: ;
            endcase
         end
         ostm_pkg::S_CLEAR: begin
            cmd.emit = 1'b1;
            cmd.action = ostm_pkg::ACT_CLEAR;
            cmd.scan_reset = 1'b1;
         end
         ostm_pkg::S_ROWSCAN: begin
            cmd.mark_row = 1'b1;
            cmd.scan_next = 1'b1;
         end
         ostm_pkg::S_PLACE: cmd.commit_place = 1'b1;
         ostm_pkg::S_DRAW: begin
            cmd.emit = 1'b1;
            cmd.action = ostm_pkg::ACT_DRAW;
         end
         ostm_pkg::S_STATUS: begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.action = ostm_pkg::ACT_STATUS;
            if (failed_ff) cmd.status = ostm_pkg::ST_FAIL;
            else if (stat.kind == ostm_pkg::KIND_SET && !updated_ff)
               cmd.status = ostm_pkg::ST_NEW;
            else cmd.status = ostm_pkg::ST_OK;
         end
         ostm_pkg::S_DELCLR: begin
            cmd.emit = 1'b1;
            cmd.action = ostm_pkg::ACT_CLEAR;
            cmd.invalidate = 1'b1;
         end
         ostm_pkg::S_TICK: begin
            cmd.tick_step = 1'b1;
            cmd.scan_next = 1'b1;
         end
         ostm_pkg::S_SWEEP: begin
            cmd.scan_next = 1'b1;
            cmd.use_scan = 1'b1;
            if (stat.scan_expired && !stat.sweep_full) begin
               cmd.emit = 1'b1;
               cmd.invalidate = 1'b1;
               cmd.action = ostm_pkg::ACT_CLEAR;
               cmd.last = stat.sweep_last;
            end
         end
         default: ;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ostm_pkg::S_IDLE) |-> !cmd.emit)
      else $error("emit while idle");
   a_start_leave: assert property (@(posedge clock) disable iff (reset)
      (!busy && start) |=> busy)
      else $error("accepted item not started");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ostm_pkg::S_STATUS) |=> !busy)
      else $error("status not final");
`endif

endmodule
